@@ hw/rtl/bbcs_pkg.sv @@
package bbcs_pkg;

  // Field and state widths
  localparam int COL_BITS   = 12;
  localparam int COUNT_BITS = 24;
  localparam int SUM_BITS   = COUNT_BITS + COL_BITS;
  localparam int PIX_W      = 8;
  localparam int COLUMN_W   = 12;
  localparam int FW_W       = 13;
  localparam int MIN_W      = 16;
  localparam int ANG_W      = 16;
  localparam int LIN_W      = 15;
  localparam int CENT_W     = 16;

  // Stream and config port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Region geometry: W/3 and W/2 both fit in one bit less than W
  localparam int SIDE_W = FW_W - 1;
  localparam int HALF_W = SIDE_W - 1;
  localparam int MID_W  = FW_W - 1;
  localparam int HI_W   = FW_W + 4;
  localparam int STEER_W = 32;

  // Shared divider geometry
  localparam int DIV_Q_W    = 16;
  localparam int DIV_STEP_W = $clog2(DIV_Q_W);
  localparam int DIV_NUM_W  = (SUM_BITS + 4 > STEER_W) ? SUM_BITS + 4 : STEER_W;
  localparam int DIV_DEN_W  = (COUNT_BITS > DIV_Q_W) ? COUNT_BITS : DIV_Q_W;
  localparam int DIV_HI_W   = DIV_NUM_W - DIV_Q_W;
  localparam int DIV_CMP_W  = (DIV_HI_W > DIV_DEN_W) ? DIV_HI_W : DIV_DEN_W;

  // Command limits and constants
  localparam int CMD_MAX    = 16384;
  // ceil(2^16 / 3): W * SIDE_RECIP >> 16 gives W/3 for any 13-bit width
  localparam int SIDE_RECIP = 21846;

  // Register reset values
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST = FW_W'(640);
  localparam logic [PIX_W-1:0] MATCH_VALUE_RST = PIX_W'(255);
  localparam logic [MIN_W-1:0] MIN_PIXELS_RST  = MIN_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH = 2'd0,
    CFG_MATCH_VALUE = 2'd1,
    CFG_MIN_PIXELS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENT,
    ST_GEOM,
    ST_ANG_GO,
    ST_ANG,
    ST_LIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [FW_W-1:0]  frame_width;
    logic [PIX_W-1:0] match_value;
    logic [MIN_W-1:0] min_pixels;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [ANG_W-1:0]  angular_rate;
    logic [LIN_W-1:0]  linear_speed;
    logic              target_seen;
    logic [CENT_W-1:0] centroid;
  } res_t;

endpackage

@@ hw/rtl/bbcs_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Quotient saturates to all ones when it would not fit in DIV_Q_W bits.
module bbcs_div
  import bbcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [DIV_DEN_W-1:0]  rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0]  den_r, den_nxt;
  logic [DIV_Q_W-1:0]    quo_r, quo_nxt;

  logic [DIV_CMP_W-1:0]  hi_ext;
  logic [DIV_CMP_W-1:0]  den_ext;
  logic [DIV_DEN_W:0]    trial;
  logic [DIV_DEN_W:0]    diff;
  logic                  ge;

  // Upper numerator bits against divisor: overflow check and first remainder
  assign hi_ext  = DIV_CMP_W'(req.num[DIV_NUM_W-1:DIV_Q_W]);
  assign den_ext = DIV_CMP_W'(req.den);

  // One shift-and-subtract step
  assign trial = {rem_r, quo_r[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      ovf_nxt  = (hi_ext >= den_ext);
      step_nxt = '0;
      rem_nxt  = hi_ext[DIV_DEN_W-1:0];
      den_nxt  = req.den;
      quo_nxt  = req.num[DIV_Q_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_nxt  = {quo_r[DIV_Q_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_STEP_W'(DIV_Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = ovf_r ? {DIV_Q_W{1'b1}} : quo_r;

endmodule

@@ hw/rtl/bbcs_ctrl.sv @@
// Match accumulators and the frame-end sequencer driving the shared divider.
module bbcs_ctrl
  import bbcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  logic [PIX_W-1:0]    pixel_value,
  input  logic [COLUMN_W-1:0] column,
  input  logic                last_of_frame,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp,
  input  logic                slot_free,
  output res_t                res
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [CENT_W-1:0]     c_r, c_nxt;
  logic [SIDE_W-1:0]     side_r, side_nxt;
  logic [SIDE_W-1:0]     side1_r, side1_nxt;
  logic [HALF_W-1:0]     half1_r, half1_nxt;
  logic [CENT_W-1:0]     d_r, d_nxt;
  logic                  outer_r, outer_nxt;
  logic                  neg_r, neg_nxt;
  logic                  seen_r, seen_nxt;
  logic [LIN_W-1:0]      mag_r, mag_nxt;
  logic [LIN_W-1:0]      lin_r, lin_nxt;
  logic                  res_valid;

  logic                  hit;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [SUM_BITS-1:0]   sum_new;
  logic                  seen_new;

  logic [FW_W+15:0]      side_prod;
  logic [SIDE_W-1:0]     side_q;
  logic [HALF_W-1:0]     half;
  logic [MID_W-1:0]      mid;
  logic [CENT_W-1:0]     lo;
  logic [CENT_W-1:0]     m16;
  logic [HI_W-1:0]       hi;
  logic [HI_W-1:0]       c_ext;
  logic                  below, above;

  logic [STEER_W-1:0]    ang_num, ang_den;
  logic [STEER_W-1:0]    pos, t3, lin_num;
  logic [LIN_W-1:0]      q_sat;
  logic [ANG_W-1:0]      mag_ext;

  // Match accumulation
  assign hit      = (pixel_value == cfg.match_value) && (count_r != CNT_MAX);
  assign cnt_new  = hit ? count_r + 1'b1 : count_r;
  assign sum_new  = hit ? sum_r + SUM_BITS'(COL_BITS'(column)) : sum_r;
  assign seen_new = (STEER_W'(cnt_new) > STEER_W'(cfg.min_pixels));

  // W/3 by reciprocal multiply
  assign side_prod = (FW_W+16)'(cfg.frame_width) * (FW_W+16)'(SIDE_RECIP);
  assign side_q    = side_prod[16 +: SIDE_W];

  // Region bounds from W/3 and W/2
  assign half  = side_r[SIDE_W-1:1];
  assign mid   = cfg.frame_width[FW_W-1:1];
  assign lo    = {side_r, 4'b0000};
  assign m16   = {mid, 4'b0000};
  assign hi    = {cfg.frame_width - FW_W'(side_r), 4'b0000};
  assign c_ext = HI_W'(c_r);
  assign below = (c_r < lo);
  assign above = (c_ext > hi);

  // Turn-rate division operands, rounded: (2n + den) / (2 den)
  always_comb begin
    if (outer_r) begin
      ang_num = (STEER_W'(side1_r) << 15) + (STEER_W'(d_r) << 13)
              + (STEER_W'(side1_r) << 2) + STEER_W'(side1_r);
      ang_den = (STEER_W'(side1_r) << 3) + (STEER_W'(side1_r) << 1);
    end else begin
      ang_num = (STEER_W'(d_r) << 11) + (STEER_W'(half1_r) << 2) + STEER_W'(half1_r);
      ang_den = (STEER_W'(half1_r) << 3) + (STEER_W'(half1_r) << 1);
    end
  end

  // Forward-speed operands in the middle band
  assign pos     = STEER_W'(half1_r) << 16;
  assign t3      = (STEER_W'(d_r) << 11) + (STEER_W'(d_r) << 10);
  assign lin_num = ((pos - t3) << 1) + (STEER_W'(half1_r) << 2) + STEER_W'(half1_r);

  // Command saturation
  assign q_sat = (div_rsp.q > DIV_Q_W'(CMD_MAX)) ? LIN_W'(CMD_MAX) : div_rsp.q[LIN_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    c_nxt       = c_r;
    side_nxt    = side_r;
    side1_nxt   = side1_r;
    half1_nxt   = half1_r;
    d_nxt       = d_r;
    outer_nxt   = outer_r;
    neg_nxt     = neg_r;
    seen_nxt    = seen_r;
    mag_nxt     = mag_r;
    lin_nxt     = lin_r;
    div_req     = '0;
    pix_ready   = 1'b0;
    res_valid   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          count_nxt = cnt_new;
          sum_nxt   = sum_new;
          if (last_of_frame) begin
            count_nxt = '0;
            sum_nxt   = '0;
            seen_nxt  = seen_new;
            if (seen_new) begin
              div_req.start = 1'b1;
              div_req.num   = DIV_NUM_W'({sum_new, 4'b0000});
              div_req.den   = DIV_DEN_W'(cnt_new);
              state_nxt     = ST_CENT;
            end else begin
              c_nxt     = '0;
              mag_nxt   = '0;
              lin_nxt   = '0;
              neg_nxt   = 1'b0;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_CENT: begin
        if (div_rsp.done) begin
          c_nxt     = div_rsp.q;
          side_nxt  = side_q;
          state_nxt = ST_GEOM;
        end
      end
      ST_GEOM: begin
        side1_nxt = (side_r == '0) ? SIDE_W'(1) : side_r;
        half1_nxt = (half == '0) ? HALF_W'(1) : half;
        outer_nxt = below || above;
        if (below) begin
          d_nxt   = lo - c_r;
          neg_nxt = 1'b0;
        end else if (above) begin
          d_nxt   = CENT_W'(c_ext - hi);
          neg_nxt = 1'b1;
        end else begin
          neg_nxt = (c_r > m16);
          d_nxt   = (c_r > m16) ? c_r - m16 : m16 - c_r;
        end
        if (!below && !above && (c_r == m16)) begin
          mag_nxt   = '0;
          lin_nxt   = LIN_W'(CMD_MAX);
          neg_nxt   = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_ANG_GO;
        end
      end
      ST_ANG_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(ang_num);
        div_req.den   = DIV_DEN_W'(ang_den);
        state_nxt     = ST_ANG;
      end
      ST_ANG: begin
        if (div_rsp.done) begin
          mag_nxt = q_sat;
          lin_nxt = '0;
          if (outer_r || (t3 >= pos)) begin
            state_nxt = ST_EMIT;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(lin_num);
            div_req.den   = DIV_DEN_W'(ang_den);
            state_nxt     = ST_LIN;
          end
        end
      end
      ST_LIN: begin
        if (div_rsp.done) begin
          lin_nxt   = q_sat;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    side_r  <= side_nxt;
    side1_r <= side1_nxt;
    half1_r <= half1_nxt;
    d_r     <= d_nxt;
    outer_r <= outer_nxt;
    neg_r   <= neg_nxt;
    seen_r  <= seen_nxt;
    mag_r   <= mag_nxt;
    lin_r   <= lin_nxt;
  end

  // Sign goes on after rounding
  assign mag_ext          = ANG_W'(mag_r);
  assign res.valid        = res_valid;
  assign res.angular_rate = neg_r ? ANG_W'(0) - mag_ext : mag_ext;
  assign res.linear_speed = lin_r;
  assign res.target_seen  = seen_r;
  assign res.centroid     = c_r;

endmodule

@@ hw/rtl/bright_blob_centroid_steering.sv @@
// Bright-blob centroid steering.
// in_*  : one pixel request per beat; tdata = pixel_value[7:0], column[19:8];
//         tlast marks the final pixel of the frame.
// out_* : one steering command per frame; tdata = angular_rate[15:0],
//         linear_speed[30:16], centroid[46:31]; tuser = target_seen.
// cfg_* : register writes (0 frame_width, 1 match_value, 2 min_pixels),
//         always ready; only to be written while the block is idle.
// Throughput: a non-final pixel is taken every cycle while the sequencer is
// idle. The final pixel starts a run on the shared 16-step divider: centroid,
// geometry (W/3 by reciprocal multiply), turn rate and, in the middle band,
// forward speed, then the hand-over; in_tready is low meanwhile. The outer
// bands skip forward speed, dead centre skips the turn rate too, and an unseen
// target goes straight to the hand-over. A stalled receiver holds the command;
// pixels of the next frame are still taken, and its command waits in the
// sequencer, with in_tready low, until the register frees.
// Reset restores the register defaults (640, 255, 10) and clears counters.
module bright_blob_centroid_steering
  import bbcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pixel_value[7:0], column[19:8]
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // angular_rate, linear_speed, centroid
  output logic                  out_tuser,  // target_seen
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;
  logic     slot_free;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH: cfg_nxt.frame_width = cfg_data[FW_W-1:0];
        CFG_MATCH_VALUE: cfg_nxt.match_value = cfg_data[PIX_W-1:0];
        CFG_MIN_PIXELS:  cfg_nxt.min_pixels  = cfg_data[MIN_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width <= FRAME_WIDTH_RST;
      cfg_r.match_value <= MATCH_VALUE_RST;
      cfg_r.min_pixels  <= MIN_PIXELS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bbcs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .pix_valid     (in_tvalid),
    .pix_ready     (in_tready),
    .pixel_value   (in_tdata[PIX_W-1:0]),
    .column        (in_tdata[PIX_W+COLUMN_W-1:PIX_W]),
    .last_of_frame (in_tlast),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .slot_free     (slot_free),
    .res           (res)
  );

  bbcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output register
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && slot_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, res.centroid, res.linear_speed, res.angular_rate};
      out_user_nxt  = res.target_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
